FILE: hw/rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur block.
// Used by the front end, the queue, the back end and the top level; no dependencies.
package bb3_pkg;

    // Default line length the row stores are sized for.
    localparam int DEF_MAX_WIDTH = 1024;

    // Configuration register widths, indexes and reset values.
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

    // Pixel layout: red in the lowest byte, then green, then blue.
    localparam int CH_W  = 8;
    localparam int NCH   = 3;
    localparam int PIX_W = CH_W * NCH;
    localparam int NCELL = 9;
    localparam int CNT_W = 4;

    // Queue between the front and back ends.
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One neighborhood ready for averaging: cells outside the frame are zero.
    typedef struct packed {
        logic [NCELL-1:0][PIX_W-1:0] cells;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } t_win_item;

    // Queue fill status seen by both ends.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_status;

endpackage

FILE: hw/rtl/bb3_fifo.sv
// Short queue of neighborhood items between the front and back ends.
// Depends on bb3_pkg for the item and status types.
module bb3_fifo
    import bb3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_win_item i_push_item,
    input  logic      i_pop,
    output t_win_item o_item,
    output t_q_status o_status
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_win_item         r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0] r_count;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wp = (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    // Storage is written only; the head is read below.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_item         = r_mem[r_rp];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

endmodule

FILE: hw/rtl/bb3_front.sv
// Front end of the box blur: configuration, raster tracking, row stores and window.
// Depends on bb3_pkg; feeds neighborhood items into bb3_fifo.
module bb3_front
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_pixel,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_win_item             o_push_item
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = ((FW_W > AW) ? FW_W : AW) + 1;
    localparam int RW = FH_W + 1;

    // Configuration and raster positions.
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [AW-1:0]   r_in_col;
    logic [RW-1:0]   r_in_row;
    logic [AW-1:0]   r_out_col;
    logic [FH_W-1:0] r_out_row;
    logic [AW-1:0]   n_in_col;
    logic [RW-1:0]   n_in_row;
    logic [AW-1:0]   n_out_col;
    logic [FH_W-1:0] n_out_row;

    // Row stores, alternating by row parity, and their read data.
    logic [PIX_W-1:0] r_mem_a [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_b [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_a;
    logic [PIX_W-1:0] r_rd_b;

    // Second stage: the item whose row-store data has just arrived.
    logic             r_f1_v;
    logic             r_f1_emit;
    logic             r_f1_last;
    logic             r_f1_par;
    logic [PIX_W-1:0] r_f1_px;
    logic             r_f1_rv0;
    logic             r_f1_rv2;
    logic             r_f1_cv0;
    logic             r_f1_cv2;
    logic [CNT_W-1:0] r_f1_count;

    // Two previous columns: rows above, middle and current.
    logic [PIX_W-1:0] r_win [6];

    logic [PW-1:0]    w_eff_width;
    logic [RW-1:0]    w_eff_height;
    logic             w_pixel_phase;
    logic             w_act;
    logic [PIX_W-1:0] w_px;
    logic             w_emit;
    logic             w_last;
    logic [PW-1:0]    w_in_col_inc;
    logic [PW-1:0]    w_out_col_inc;
    logic [RW-1:0]    w_out_row_inc;
    logic             w_rv0;
    logic             w_rv2;
    logic             w_cv0;
    logic             w_cv2;
    logic [1:0]       w_nrows;
    logic [1:0]       w_ncols;
    logic [CNT_W-1:0] w_count;
    logic [PIX_W-1:0] w_top;
    logic [PIX_W-1:0] w_mid;
    logic [NCELL-1:0] w_mask;
    logic [NCELL-1:0][PIX_W-1:0] w_raw;

    // Effective frame size: zero acts as one, width is capped at the store depth.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_width = PW'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_eff_width = PW'(MAX_WIDTH);
        end else begin
            w_eff_width = PW'(r_frame_width);
        end
        w_eff_height = (r_frame_height == '0) ? RW'(1) : RW'(r_frame_height);
    end

    // Accept whenever the queue has room for everything in flight.
    assign o_ready = ({1'b0, i_q_status.count} + {{QCNT_W{1'b0}}, r_f1_v})
                     < (QCNT_W + 1)'(QDEPTH);

    // Classify the item: a drain item while pixels are expected does nothing.
    assign w_pixel_phase = (r_in_row < w_eff_height);
    assign w_act         = i_valid && o_ready && !(w_pixel_phase && i_op);
    assign w_px          = w_pixel_phase ? i_pixel : '0;

    // Output position bookkeeping and neighborhood validity.
    always_comb begin
        w_in_col_inc  = PW'(r_in_col) + PW'(1);
        w_out_col_inc = PW'(r_out_col) + PW'(1);
        w_out_row_inc = RW'(r_out_row) + RW'(1);
        w_emit  = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
        w_rv0   = (r_out_row != '0);
        w_rv2   = (w_out_row_inc < w_eff_height);
        w_cv0   = (r_out_col != '0);
        w_cv2   = (w_out_col_inc < w_eff_width);
        w_last  = (w_out_row_inc >= w_eff_height) && (w_out_col_inc >= w_eff_width);
        w_nrows = 2'd1 + {1'b0, w_rv0} + {1'b0, w_rv2};
        w_ncols = 2'd1 + {1'b0, w_cv0} + {1'b0, w_cv2};
        w_count = {2'b00, w_nrows} * {2'b00, w_ncols};
    end

    // Next raster positions; the final result of a frame restarts everything.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_emit && w_last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else begin
            if (w_emit) begin
                if (w_out_col_inc >= w_eff_width) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = w_out_col_inc[AW-1:0];
                end
            end
            if (w_in_col_inc >= w_eff_width) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = w_in_col_inc[AW-1:0];
            end
        end
    end

    // Configuration registers and positions; any write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_act) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Row stores: read the old entry and overwrite the row two above in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_act) begin
            r_rd_a <= r_mem_a[r_in_col];
            r_rd_b <= r_mem_b[r_in_col];
            if (r_in_row[0]) begin
                r_mem_b[r_in_col] <= w_px;
            end else begin
                r_mem_a[r_in_col] <= w_px;
            end
        end
    end

    // Second stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= w_act;
        end
    end

    // Second stage payload.
    always_ff @(posedge i_clk) begin
        if (w_act) begin
            r_f1_emit  <= w_emit;
            r_f1_last  <= w_last;
            r_f1_par   <= r_in_row[0];
            r_f1_px    <= w_px;
            r_f1_rv0   <= w_rv0;
            r_f1_rv2   <= w_rv2;
            r_f1_cv0   <= w_cv0;
            r_f1_cv2   <= w_cv2;
            r_f1_count <= w_count;
        end
    end

    // The store written at this row's parity holds the row two above.
    assign w_top = r_f1_par ? r_rd_b : r_rd_a;
    assign w_mid = r_f1_par ? r_rd_a : r_rd_b;

    // Assemble the neighborhood, zeroing cells that fall outside the frame.
    always_comb begin
        w_mask = {r_f1_rv2 & r_f1_cv2, r_f1_rv2, r_f1_rv2 & r_f1_cv0,
                  r_f1_cv2, 1'b1, r_f1_cv0,
                  r_f1_rv0 & r_f1_cv2, r_f1_rv0, r_f1_rv0 & r_f1_cv0};
        w_raw[0] = r_win[0];
        w_raw[1] = r_win[3];
        w_raw[2] = w_top;
        w_raw[3] = r_win[1];
        w_raw[4] = r_win[4];
        w_raw[5] = w_mid;
        w_raw[6] = r_win[2];
        w_raw[7] = r_win[5];
        w_raw[8] = r_f1_px;
        for (int k = 0; k < NCELL; k++) begin
            o_push_item.cells[k] = w_mask[k] ? w_raw[k] : '0;
        end
        o_push_item.count = r_f1_count;
        o_push_item.last  = r_f1_last;
    end

    assign o_push = r_f1_v && r_f1_emit;

    // Window shift; cleared at reset, on a register write and after a frame ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_win <= '{default: '0};
        end else if (r_f1_v) begin
            if (r_f1_emit && r_f1_last) begin
                r_win <= '{default: '0};
            end else begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= w_top;
                r_win[4] <= w_mid;
                r_win[5] <= r_f1_px;
            end
        end
    end

endmodule

FILE: hw/rtl/bb3_back.sv
// Back end of the box blur: channel sums, rounded division and the output register.
// Depends on bb3_pkg; pops neighborhood items from bb3_fifo.
module bb3_back
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_status        i_q_status,
    input  t_win_item        i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_last
);

    localparam int SUM_W  = 12;
    localparam int NUM_W  = SUM_W + 1;
    localparam int X_W    = NUM_W - 1;
    localparam int PROD_W = 2 * X_W;

    // Reciprocals for exact floor division by 3 and 9 of the halved or quartered
    // numerators, which never exceed 2300.
    localparam logic [X_W-1:0] DIV3_MUL = 12'd2731;
    localparam int             DIV3_SH  = 13;
    localparam logic [X_W-1:0] DIV9_MUL = 12'd1821;
    localparam int             DIV9_SH  = 14;

    localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 4'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 4'd3;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 4'd4;
    localparam logic [CNT_W-1:0] CNT_SIX   = 4'd6;
    localparam logic [CNT_W-1:0] CNT_NINE  = 4'd9;

    logic                        r_b0_v;
    logic [NCH-1:0][NUM_W-1:0]   r_b0_num;
    logic [CNT_W-1:0]            r_b0_count;
    logic                        r_b0_last;
    logic                        r_out_v;
    logic [PIX_W-1:0]            r_out_pixel;
    logic                        r_out_last;
    logic [NCH-1:0][NUM_W-1:0]   w_num;
    logic [PIX_W-1:0]            w_quot;
    logic                        w_b0_take;
    logic                        w_b1_take;

    // Floor of num / (2 * count): shifts for powers of two, reciprocals otherwise.
    function automatic logic [CH_W-1:0] div_round(input logic [NUM_W-1:0] num,
                                                  input logic [CNT_W-1:0] cnt);
        logic [X_W-1:0]    x;
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   q;
        x    = '0;
        prod = '0;
        q    = '0;
        unique case (cnt)
            CNT_ONE:   q = CH_W'(num >> 1);
            CNT_TWO:   q = CH_W'(num >> 2);
            CNT_FOUR:  q = CH_W'(num >> 3);
            CNT_THREE: begin
                x    = X_W'(num >> 1);
                prod = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, DIV3_MUL};
                q    = CH_W'(prod >> DIV3_SH);
            end
            CNT_SIX: begin
                x    = X_W'(num >> 2);
                prod = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, DIV3_MUL};
                q    = CH_W'(prod >> DIV3_SH);
            end
            CNT_NINE: begin
                x    = X_W'(num >> 1);
                prod = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, DIV9_MUL};
                q    = CH_W'(prod >> DIV9_SH);
            end
            default:   q = '0;
        endcase
        return q;
    endfunction

    // Stage handshakes: each register moves when the one after it can take.
    assign w_b1_take = !r_out_v || i_ready;
    assign w_b0_take = !r_b0_v || w_b1_take;
    assign o_pop     = w_b0_take && !i_q_status.empty;

    // Per channel sum, doubled and offset by the count for half-up rounding.
    always_comb begin
        logic [SUM_W-1:0] sum;
        for (int ch = 0; ch < NCH; ch++) begin
            sum = '0;
            for (int k = 0; k < NCELL; k++) begin
                sum = sum + SUM_W'(i_item.cells[k][ch*CH_W +: CH_W]);
            end
            w_num[ch] = {sum, 1'b0} + NUM_W'(i_item.count);
        end
    end

    // Division of each channel.
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            w_quot[ch*CH_W +: CH_W] = div_round(r_b0_num[ch], r_b0_count);
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_b0_take) begin
                r_b0_v <= o_pop;
            end
            if (w_b1_take) begin
                r_out_v <= r_b0_v;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b0_num   <= w_num;
            r_b0_count <= i_item.count;
            r_b0_last  <= i_item.last;
        end
        if (w_b1_take && r_b0_v) begin
            r_out_pixel <= w_quot;
            r_out_last  <= r_b0_last;
        end
    end

    assign o_valid = r_out_v;
    assign o_pixel = r_out_pixel;
    assign o_last  = r_out_last;

endmodule

FILE: hw/rtl/box_blur_3x3.sv
// 3x3 box blur on RGB pixels. Throughput: one item per cycle while the queue has
// room, set by the single read-and-write port of each row store. A result passes
// the second stage, the queue, the numerator register and the output register after
// the item that causes it; that item comes width+1 items after the result's own pixel.
// Reset is synchronous, active low: positions, window, queue and configuration
// return to their defaults; row stores are not cleared.
module box_blur_3x3
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  i_s_axis_tuser,  // op
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIX_W-1:0]      o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  o_m_axis_tlast   // last_pixel
);

    logic      w_push;
    logic      w_pop;
    t_win_item w_push_item;
    t_win_item w_head_item;
    t_q_status w_q_status;

    // Front end: classification, row stores and window.
    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_pixel     (i_s_axis_tdata),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    // Queue decoupling the two ends.
    bb3_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_item      (w_head_item),
        .o_status    (w_q_status)
    );

    // Back end: averaging and output register.
    bb3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_item     (w_head_item),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_pixel    (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_status.count != QCNT_W'(QDEPTH)) || w_pop)
        else $error("queue pushed while full");

    // The back end must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("queue popped while empty");

    // Reset leaves no result pending and an empty queue.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && w_q_status.empty)
        else $error("state survived reset");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking bench for box_blur_3x3: streams RGB frames through the block, predicts
// every blurred pixel locally and compares it with the output stream, field by field.
// Depends on bb3_pkg and the box_blur_3x3 RTL; needs nothing else.
module testbench;
    import bb3_pkg::*;

    localparam int MAXW         = DEF_MAX_WIDTH;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 8;
    localparam int HOLD_OFF     = 300;
    localparam int RANDOM_ITEMS = 480;
    localparam int MAX_PRINTED  = 40;

    typedef enum logic {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} t_op;
    typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER, PAT_EXTREME} t_pattern;
    typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // One blurred output pixel as the block should deliver it.
    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_blur_px;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [PIX_W-1:0]      i_s_axis_tdata = '0;  // red_in, green_in, blue_in
    logic                  i_s_axis_tuser = 1'b0;  // op
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      o_m_axis_tdata;  // red_out, green_out, blue_out
    logic                  o_m_axis_tlast;  // last_pixel

    box_blur_3x3 DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the filter state and of the configuration.
    logic [PIX_W-1:0] upper_row [MAXW];
    logic [PIX_W-1:0] middle_row [MAXW];
    logic [PIX_W-1:0] win_col [6];
    int unsigned      in_row, in_col, out_row, out_col;
    logic [FW_W-1:0]  cfg_width = FW_RESET;
    logic [FH_W-1:0]  cfg_height = FH_RESET;
    t_blur_px         blurred_q [$];

    // Bookkeeping shared by the stimulus, the checker and the summary.
    int items_in = 0;
    int ignored_items = 0;
    int results_out = 0;
    int frames_done = 0;
    int mismatches = 0;
    int frame_w = MAXW;
    int frame_h = FH_RESET;
    int burst_left = 0;
    bit bursty = 1'b1;
    int hold_off_req = 0;

    function automatic void restart_positions();
        for (int i = 0; i < 6; i++) win_col[i] = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // Advances the local filter by one accepted item; returns 1 when a pixel comes out.
    function automatic bit compute_blur(input logic op, input logic [PIX_W-1:0] pix_in,
                                        output t_blur_px res);
        int unsigned      w, h, count, sum;
        logic [PIX_W-1:0] px, top, mid;
        logic [PIX_W-1:0] cells [9];
        logic [CH_W-1:0]  mean [NCH];
        bit               row_ok [3];
        bit               col_ok [3];
        bit               emit;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        res = '{default: '0};
        // A drain item while pixels are still expected changes nothing.
        if (in_row < h && op == OP_DRAIN) begin
            ignored_items++;
            return 1'b0;
        end
        // Once the frame's pixels are in, pixel data is dropped and the item drains.
        px = (in_row < h) ? pix_in : '0;
        top = upper_row[in_col];
        mid = middle_row[in_col];
        upper_row[in_col] = mid;
        middle_row[in_col] = px;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (emit) begin
            for (int r = 0; r < 3; r++) begin
                cells[r * 3] = win_col[r];
                cells[r * 3 + 1] = win_col[3 + r];
            end
            cells[2] = top;
            cells[5] = mid;
            cells[8] = px;
            row_ok = '{out_row != 0, 1'b1, out_row + 1 < h};
            col_ok = '{out_col != 0, 1'b1, out_col + 1 < w};
            count = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (row_ok[r] && col_ok[c]) count++;
            // Rounded half up in exact integers.
            for (int k = 0; k < NCH; k++) begin
                sum = 0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        if (row_ok[r] && col_ok[c]) sum += cells[r * 3 + c][k * CH_W +: CH_W];
                mean[k] = CH_W'((2 * sum + count) / (2 * count));
            end
            res.red = mean[0];
            res.green = mean[1];
            res.blue = mean[2];
            res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            if (res.last) begin
                restart_positions();
                return 1'b1;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end

        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = top;
        win_col[4] = mid;
        win_col[5] = px;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        return emit;
    endfunction

    // Input side: register writes and accepted items update the prediction.
    always @(posedge i_clk) begin
        t_blur_px res;
        if (!i_rst_n) begin
            cfg_width = FW_RESET;
            cfg_height = FH_RESET;
            restart_positions();
            blurred_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  cfg_width = i_cfg_wdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height = i_cfg_wdata[FH_W-1:0];
                endcase
                restart_positions();
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_in++;
                if (compute_blur(i_s_axis_tuser, i_s_axis_tdata, res)) blurred_q.push_back(res);
            end
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t, result %0d: %s expected %0d got %0d",
                     $time, results_out, what, want, got);
    endtask

    // Output side: every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_blur_px want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            results_out++;
            if (blurred_q.size() == 0) begin
                report_mismatch("result with nothing pending", 0, o_m_axis_tdata);
            end else begin
                want = blurred_q.pop_front();
                if (o_m_axis_tdata[0 * CH_W +: CH_W] !== want.red)
                    report_mismatch("red", want.red, o_m_axis_tdata[0 * CH_W +: CH_W]);
                if (o_m_axis_tdata[1 * CH_W +: CH_W] !== want.green)
                    report_mismatch("green", want.green, o_m_axis_tdata[1 * CH_W +: CH_W]);
                if (o_m_axis_tdata[2 * CH_W +: CH_W] !== want.blue)
                    report_mismatch("blue", want.blue, o_m_axis_tdata[2 * CH_W +: CH_W]);
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last_pixel", want.last, o_m_axis_tlast);
                if (want.last) frames_done++;
            end
        end
    end

    // Receiver: switches between stall patterns, and honors a long hold-off on request.
    int       hold_left = 0;
    int       rx_run = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_STEADY;

    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_run = $urandom_range(20, 200);
            end
            rx_run--;
            case (rx_mode)
                RX_STEADY:   i_m_axis_tready <= 1'b1;
                RX_MOSTLY:   i_m_axis_tready <= ($urandom_range(0, 99) < 75);
                RX_SPARSE:   i_m_axis_tready <= ($urandom_range(0, 99) < 25);
                RX_PERIODIC: i_m_axis_tready <= (rx_tick % 4 != 3);
            endcase
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_wr_en || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d results pending",
                         IDLE_LIMIT, blurred_q.size());
                $display("** box_blur_3x3: FAILED **");
                $finish;
            end
        end
    end

    // Offers one item, with a random gap at the start of each burst, and waits for it.
    task automatic send_item(input t_op op, input logic [PIX_W-1:0] pix);
        int gap;
        if (bursty && burst_left <= 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= pix;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input t_pattern pat, input int idx);
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        case (pat)
            PAT_WHITE:   px = '1;
            PAT_BLACK:   px = '0;
            PAT_CHECKER: px = idx[0] ? '1 : '0;
            PAT_EXTREME: begin
                for (int c = 0; c < NCH; c++)
                    case ($urandom_range(0, 3))
                        0:       px[c * CH_W +: CH_W] = 8'd0;
                        1:       px[c * CH_W +: CH_W] = 8'd1;
                        2:       px[c * CH_W +: CH_W] = 8'd254;
                        default: px[c * CH_W +: CH_W] = 8'd255;
                    endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    // Waits until every predicted pixel is out and the pipeline has settled.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Writes both size registers and records the size the block will actually use.
    task automatic set_frame(input int unsigned w_reg, input int unsigned h_reg);
        write_reg(REG_FRAME_WIDTH, w_reg);
        write_reg(REG_FRAME_HEIGHT, h_reg);
        frame_w = (w_reg[FW_W-1:0] == 0) ? 1
                : ((w_reg[FW_W-1:0] > MAXW) ? MAXW : int'(w_reg[FW_W-1:0]));
        frame_h = (h_reg[FH_W-1:0] == 0) ? 1 : int'(h_reg[FH_W-1:0]);
    endtask

    task automatic send_pixels(input int count, input t_pattern pat);
        for (int n = 0; n < count; n++) send_item(OP_PIXEL, make_pixel(pat, n));
    endtask

    // One whole frame plus its drain; noise adds ignored drains and discarded pixels.
    task automatic run_frame(input int noise_pct, input t_pattern pat);
        for (int n = 0; n < frame_w * frame_h; n++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(OP_DRAIN, PIX_W'($urandom));
            send_item(OP_PIXEL, make_pixel(pat, n));
        end
        for (int n = 0; n <= frame_w; n++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(OP_PIXEL, PIX_W'($urandom));
            else send_item(OP_DRAIN, PIX_W'($urandom));
        end
    endtask

    // Reset sizes: a partial first row gives no result before any register write.
    task automatic test_reset_size();
        send_pixels(40, PAT_RANDOM);
        wait_drained();
    endtask

    // Saturated values, half-way rounding, single pixel frames and both kinds of noise.
    task automatic test_directed();
        set_frame(3, 3);
        run_frame(0, PAT_WHITE);
        set_frame(0, 0);
        send_item(OP_DRAIN, '1);
        send_item(OP_PIXEL, '0);
        send_item(OP_PIXEL, '1);
        send_item(OP_DRAIN, '0);
        set_frame(2, 1);
        run_frame(0, PAT_CHECKER);
        wait_drained();
    endtask

    // Largest and smallest register values, including clamped and partial frames.
    task automatic test_register_extremes();
        set_frame(2047, 1);
        send_pixels(30, PAT_EXTREME);
        set_frame(3, 65535);
        send_pixels(20, PAT_RANDOM);
        set_frame(1, 4);
        run_frame(0, PAT_EXTREME);
        set_frame(1, 65535);
        send_pixels(10, PAT_CHECKER);
        set_frame(32, 2);
        run_frame(0, PAT_RANDOM);
        wait_drained();
    endtask

    // Frames that follow each other without a register write or any idle cycle.
    task automatic test_back_to_back();
        bursty = 1'b0;
        set_frame(4, 3);
        run_frame(0, PAT_RANDOM);
        run_frame(0, PAT_EXTREME);
        run_frame(5, PAT_RANDOM);
        bursty = 1'b1;
        wait_drained();
    endtask

    // The receiver stops for a long time while the sender keeps pushing.
    task automatic test_backpressure();
        bursty = 1'b0;
        set_frame(8, 6);
        hold_off_req = HOLD_OFF;
        run_frame(0, PAT_RANDOM);
        bursty = 1'b1;
        wait_drained();
    endtask

    // Random sizes and content, mostly whole frames, some abandoned part way.
    task automatic test_random_frames();
        int       start;
        int       left;
        int       reps;
        int       w, h;
        t_pattern pat;
        start = items_in - ignored_items;
        while (items_in - ignored_items < start + RANDOM_ITEMS) begin
            left = start + RANDOM_ITEMS - (items_in - ignored_items);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            reps = $urandom_range(1, 2);
            // Shrink the frame so the run stays close to its item budget.
            if (reps * w * h > left) h = (left / (reps * w) > 0) ? left / (reps * w) : 1;
            set_frame(w, h);
            bursty = ($urandom_range(0, 3) != 0);
            pat = t_pattern'($urandom_range(0, 4));
            if ($urandom_range(0, 7) == 0) send_pixels($urandom_range(1, w * h), pat);
            else repeat (reps) run_frame($urandom_range(0, 10), pat);
        end
        bursty = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_size();
        test_directed();
        test_register_extremes();
        test_back_to_back();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (blurred_q.size() != 0) report_mismatch("pixels never delivered", 0, blurred_q.size());
        $display("Run covered %0d items (%0d ignored drains), %0d results, %0d whole frames,",
                 items_in, ignored_items, results_out, frames_done);
        $display("widths 1 to 64 and a clamped 2047, heights 1 to 65535, random stalls "
                 , "and a long hold-off.");
        if (mismatches == 0) begin
            $display("** box_blur_3x3: PASSED **");
        end else begin
            $display("** box_blur_3x3: FAILED **");
        end
        $finish;
    end

endmodule
